// File: rtl/core/mfrc_pkg.sv
// Package with the types, codes and constants of the meter frame receive check.
package mfrc_pkg;

  localparam int MAX_FRAME = 256;
  localparam int COUNT_W   = $clog2(MAX_FRAME + 2);
  localparam int MIN_FRAME = 10;

  localparam logic [7:0] START_MARK = 8'h68;
  localparam logic [7:0] END_MARK   = 8'h16;
  localparam logic [7:0] WILD_BYTE  = 8'hAA;
  localparam logic [7:0] BCAST_BYTE = 8'h99;

  localparam int DIR_BIT = 7;
  localparam int ERR_BIT = 6;

  localparam logic REG_OWN_ADDRESS = 1'b0;
  localparam logic REG_SKIP_CHECK  = 1'b1;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_START  = 4'd1;
  localparam logic [3:0] ST_SHORT     = 4'd2;
  localparam logic [3:0] ST_HEADER    = 4'd3;
  localparam logic [3:0] ST_ADDRESS   = 4'd4;
  localparam logic [3:0] ST_CHECKSUM  = 4'd5;
  localparam logic [3:0] ST_END       = 4'd6;
  localparam logic [3:0] ST_DIRECTION = 4'd7;
  localparam logic [3:0] ST_ERR_REPLY = 4'd8;
  localparam logic [3:0] ST_TOO_LONG  = 4'd9;

  localparam logic [1:0] KIND_ERROR     = 2'd0;
  localparam logic [1:0] KIND_OWN       = 2'd1;
  localparam logic [1:0] KIND_BROADCAST = 2'd2;
  localparam logic [1:0] KIND_WILDCARD  = 2'd3;

  localparam int M_OWN = 0;
  localparam int M_BC  = 1;
  localparam int M_WC  = 2;
  localparam int M_MIX = 3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [1:0] address_kind;
    logic [7:0] control_code;
    logic [7:0] length_field;
  } out_item_t;

endpackage

// File: rtl/core/meter_frame_receive_check.sv
// Top level of the meter frame receive check: byte parser, verdict logic and output queue.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid, in_stall   in_item  (rx_byte, last_byte)
//   out_     output     out_valid, out_stall out_item (status, kind, control, length)
//   cfg_     input      cfg_wr_en            cfg_index, cfg_wdata
//
// One byte is taken per cycle unless in_stall is high; the frame state updates in
// the same cycle. A verdict is registered in the output register, or in the single skid
// entry when the output is stalled; these two hold verdicts, and in_stall rises only
// when both are full. Reset is synchronous and clears the frame state, the registers
// and the output queue; no clearing pass is needed.
module meter_frame_receive_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfrc_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mfrc_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [47:0]        cfg_wdata
);
  import mfrc_pkg::*;

  logic [47:0]        own_address_r;
  logic               skip_check_r;
  logic               in_frame_r, in_frame_nxt;
  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]         running_sum_r, running_sum_nxt;
  logic [7:0]         previous_byte_r, previous_byte_nxt;
  logic               header_ok_r, header_ok_nxt;
  logic [3:0]         match_flags_r, match_flags_nxt;
  logic [7:0]         control_seen_r, control_seen_nxt;
  logic [7:0]         length_seen_r, length_seen_nxt;

  logic               out_valid_r;
  out_item_t          out_item_r;
  logic               skid_valid_r;
  out_item_t          skid_item_r;

  logic               accept;
  logic               produce;
  out_item_t          result;
  logic [7:0]         b;
  logic [7:0]         own_byte;
  logic [7:0]         sum_before_prev;
  logic [1:0]         kind;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid_r;
  assign b        = in_item.rx_byte;

  always_comb begin
    case (byte_count_r[2:0])
      3'd1: own_byte = own_address_r[47:40];
      3'd2: own_byte = own_address_r[39:32];
      3'd3: own_byte = own_address_r[31:24];
      3'd4: own_byte = own_address_r[23:16];
      3'd5: own_byte = own_address_r[15:8];
      3'd6: own_byte = own_address_r[7:0];
      default: own_byte = 8'd0;
    endcase
  end

  assign sum_before_prev = running_sum_r - previous_byte_r;

  always_comb begin
    in_frame_nxt      = in_frame_r;
    byte_count_nxt    = byte_count_r;
    running_sum_nxt   = running_sum_r;
    previous_byte_nxt = previous_byte_r;
    header_ok_nxt     = header_ok_r;
    match_flags_nxt   = match_flags_r;
    control_seen_nxt  = control_seen_r;
    length_seen_nxt   = length_seen_r;
    produce           = 1'b0;
    result            = '0;
    kind              = KIND_ERROR;

    if (!in_frame_r && b != START_MARK) begin
      if (in_item.last_byte) begin
        produce       = 1'b1;
        result.status = ST_NO_START;
      end
    end else begin
      in_frame_nxt = 1'b1;
      if (byte_count_r inside {[1:6]}) begin
        if (b != own_byte) match_flags_nxt[M_OWN] = 1'b0;
        if (b != BCAST_BYTE) match_flags_nxt[M_BC] = 1'b0;
        if (b != WILD_BYTE) match_flags_nxt[M_WC] = 1'b0;
        if (b != own_byte && b != WILD_BYTE) match_flags_nxt[M_MIX] = 1'b0;
      end else if (byte_count_r == COUNT_W'(7)) begin
        if (b != START_MARK) header_ok_nxt = 1'b0;
      end else if (byte_count_r == COUNT_W'(8)) begin
        control_seen_nxt = b;
      end else if (byte_count_r == COUNT_W'(9)) begin
        length_seen_nxt = b;
      end

      if (byte_count_r < COUNT_W'(MAX_FRAME + 1)) begin
        byte_count_nxt = byte_count_r + COUNT_W'(1);
      end

      if (!in_item.last_byte) begin
        running_sum_nxt   = running_sum_r + b;
        previous_byte_nxt = b;
      end else begin
        produce = 1'b1;
        if (match_flags_nxt[M_OWN]) begin
          kind = KIND_OWN;
        end else if (match_flags_nxt[M_BC]) begin
          kind = KIND_BROADCAST;
        end else if (match_flags_nxt[M_WC] || match_flags_nxt[M_MIX]) begin
          kind = KIND_WILDCARD;
        end

        result.address_kind = kind;
        result.control_code = control_seen_nxt;
        result.length_field = length_seen_nxt;

        if (byte_count_nxt < COUNT_W'(MIN_FRAME)) begin
          result = '0;
          result.status = ST_SHORT;
        end else if (byte_count_nxt > COUNT_W'(MAX_FRAME)) begin
          result.status = ST_TOO_LONG;
        end else if (!header_ok_nxt) begin
          result.status = ST_HEADER;
        end else if (kind == KIND_ERROR && !skip_check_r) begin
          result.status = ST_ADDRESS;
        end else if (sum_before_prev != previous_byte_r) begin
          result.status = ST_CHECKSUM;
        end else if (b != END_MARK) begin
          result.status = ST_END;
        end else if (!control_seen_nxt[DIR_BIT]) begin
          result.status = ST_DIRECTION;
        end else if (control_seen_nxt[ERR_BIT]) begin
          result.status = ST_ERR_REPLY;
        end else begin
          result.status = ST_OK;
        end

        in_frame_nxt      = 1'b0;
        byte_count_nxt    = '0;
        running_sum_nxt   = '0;
        previous_byte_nxt = '0;
        header_ok_nxt     = 1'b1;
        match_flags_nxt   = '1;
        control_seen_nxt  = '0;
        length_seen_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
      skip_check_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OWN_ADDRESS: own_address_r <= cfg_wdata;
        REG_SKIP_CHECK:  skip_check_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r      <= 1'b0;
      byte_count_r    <= '0;
      running_sum_r   <= '0;
      previous_byte_r <= '0;
      header_ok_r     <= 1'b1;
      match_flags_r   <= '1;
      control_seen_r  <= '0;
      length_seen_r   <= '0;
    end else if (accept) begin
      in_frame_r      <= in_frame_nxt;
      byte_count_r    <= byte_count_nxt;
      running_sum_r   <= running_sum_nxt;
      previous_byte_r <= previous_byte_nxt;
      header_ok_r     <= header_ok_nxt;
      match_flags_r   <= match_flags_nxt;
      control_seen_r  <= control_seen_nxt;
      length_seen_r   <= length_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && produce;
      end
    end else if (accept && produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (accept && produce) begin
        out_item_r <= result;
      end
    end else if (accept && produce) begin
      skid_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/core/mfrc_checker.sv
// Port checker for the meter frame receive check, with its bind statement.
module mfrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mfrc_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input mfrc_pkg::out_item_t out_item
);
  import mfrc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("A stalled result item changed or vanished.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("The output queue is not empty after reset.");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_item.last_byte))
    else $error("A result item appeared without an accepted last byte.");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_NO_START || out_item.status == ST_SHORT)
      |-> out_item.address_kind == KIND_ERROR && out_item.control_code == 8'd0
          && out_item.length_field == 8'd0)
    else $error("A frame without content reported nonzero fields.");

  a_ok_control: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_OK
      |-> out_item.control_code[DIR_BIT] && !out_item.control_code[ERR_BIT])
    else $error("An accepted frame has a bad control code.");

endmodule

bind meter_frame_receive_check mfrc_checker u_mfrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
